// ===== rtl/core/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and codes of the shutter relay sequencer.
// ----------------------------------------------------------------------------
package srs_pkg;

  // Item opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_UP   = 2'd1;
  localparam logic [1:0] OP_DOWN = 2'd2;
  localparam logic [1:0] OP_STOP = 2'd3;

  // Motion codes, as reported in the packed status
  localparam logic [1:0] MOTION_STOP = 2'd0;
  localparam logic [1:0] MOTION_UP   = 2'd1;
  localparam logic [1:0] MOTION_DOWN = 2'd2;

  // Travel time registers
  localparam int unsigned TIME_W    = 13;
  localparam int unsigned TIME_CH   = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [TIME_W-1:0] TIME_RESET = 13'd30;

  localparam logic [CFG_IDX_W-1:0] CFG_UP_TIME_CH0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_TIME_CH1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_TIME_CH2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TIME_CH0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TIME_CH1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TIME_CH2 = 3'd5;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned FIELD_W = 6;   // relay_drive / packed_status width
  localparam int unsigned OUT_CH  = FIELD_W / 2;

  // Work request handed to every channel for one item
  typedef struct packed {
    logic       en;    // an item is processed this cycle
    logic [1:0] op;
    logic [1:0] chan;
  } srs_cmd_t;

endpackage

// ===== rtl/core/srs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// srs_cfg_regs
// Travel time register file, written through a plain write port.
// ----------------------------------------------------------------------------
module srs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [srs_pkg::TIME_W-1:0]    cfg_data_i,
  output logic [srs_pkg::TIME_W-1:0]    up_time_o   [srs_pkg::TIME_CH],
  output logic [srs_pkg::TIME_W-1:0]    down_time_o [srs_pkg::TIME_CH]
);
  import srs_pkg::*;

  logic [TIME_W-1:0] up_time_q   [TIME_CH];
  logic [TIME_W-1:0] down_time_q [TIME_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TIME_CH; i++) begin
        up_time_q[i]   <= TIME_RESET;
        down_time_q[i] <= TIME_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_UP_TIME_CH0:   up_time_q[0]   <= cfg_data_i;
        CFG_UP_TIME_CH1:   up_time_q[1]   <= cfg_data_i;
        CFG_UP_TIME_CH2:   up_time_q[2]   <= cfg_data_i;
        CFG_DOWN_TIME_CH0: down_time_q[0] <= cfg_data_i;
        CFG_DOWN_TIME_CH1: down_time_q[1] <= cfg_data_i;
        CFG_DOWN_TIME_CH2: down_time_q[2] <= cfg_data_i;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  assign up_time_o   = up_time_q;
  assign down_time_o = down_time_q;

endmodule

// ===== rtl/core/srs_channel.sv =====
// ----------------------------------------------------------------------------
// srs_channel
// Motion state of one shutter: request, applied drive and travel countdown.
// ----------------------------------------------------------------------------
module srs_channel #(
  parameter int unsigned TICKS_PER_SECOND = 10,
  parameter int unsigned CH_ID            = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  srs_pkg::srs_cmd_t          cmd_i,
  input  logic [srs_pkg::TIME_W-1:0] up_time_i,
  input  logic [srs_pkg::TIME_W-1:0] down_time_i,
  output logic [1:0]                 req_d_o,   // request after this item
  output logic [1:0]                 app_d_o    // applied motion after this item
);
  import srs_pkg::*;

  localparam int unsigned PROD_W = TIME_W + 7;  // TICKS_PER_SECOND <= 100

  logic [1:0]        req_q, req_d;
  logic [1:0]        app_q, app_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] sel_time;
  logic [PROD_W-1:0] load_val;
  logic              hit;

  assign hit      = (cmd_i.chan == CH_ID[1:0]);
  assign sel_time = (req_q == MOTION_UP) ? up_time_i : down_time_i;
  assign load_val = PROD_W'(sel_time) * PROD_W'(TICKS_PER_SECOND);

  always_comb begin
    req_d = req_q;
    app_d = app_q;
    cnt_d = cnt_q;
    if (cmd_i.en) begin
      if (cmd_i.op == OP_TICK) begin
        if (req_q != app_q) begin
          if (req_q == MOTION_STOP || app_q != MOTION_STOP) begin
            app_d = MOTION_STOP;  // stop, or dead time before reversing
          end else begin
            app_d = req_q;
            cnt_d = load_val[CNT_W-1:0];
          end
        end else if (req_q != MOTION_STOP) begin
          cnt_d = cnt_q - CNT_W'(1);
          if (cnt_d == '0) begin
            req_d = MOTION_STOP;
          end
        end
      end else if (hit) begin
        case (cmd_i.op)
          OP_UP:   req_d = MOTION_UP;
          OP_DOWN: req_d = MOTION_DOWN;
          default: req_d = MOTION_STOP;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= MOTION_STOP;
      app_q <= MOTION_STOP;
      cnt_q <= '0;
    end else begin
      req_q <= req_d;
      app_q <= app_d;
      cnt_q <= cnt_d;
    end
  end

  assign req_d_o = req_d;
  assign app_d_o = app_d;

endmodule

// ===== rtl/core/shutter_relay_sequencer.sv =====
// ----------------------------------------------------------------------------
// shutter_relay_sequencer
// Relay sequencing for up to three shutter motors with dead time on reversal.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per handshake: the operation in tuser (a 100 ms
//   tick or an up/down/stop command) and the addressed channel in tdata.
//   Commands to a channel the block does not drive are ignored but still
//   produce a result.
//   m_axis returns exactly one result per input item: relay drive and packed
//   request status, both taken after the item has taken effect.
//   The cfg port writes the six travel time registers (seconds); writes are
//   expected only while no item is in flight.
//   Path: an item accepted into the input register has its result loaded into
//   the output register once the output slot is free.
//   Throughput: one item per cycle while m_axis is not stalled; the channel
//   update between the input register and the output register is combinational.
//   Stall: a held result keeps its data; the input register still takes one
//   more item, then s_axis_tready drops until the result is taken.
//   Reset: all channels stop, relays off, countdowns zero, travel times 30 s,
//   both registers empty.
// ----------------------------------------------------------------------------
module shutter_relay_sequencer #(
  parameter int unsigned CHANNELS         = 3,
  parameter int unsigned TICKS_PER_SECOND = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [srs_pkg::TIME_W-1:0]    cfg_data_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [1:0] channel
  input  logic [1:0]                    s_axis_tuser,   // [1:0] operation
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata    // [5:0] relay_drive,
                                                        // [11:6] packed_status
);
  import srs_pkg::*;

  // channels beyond the third have no place in the 6-bit result fields
  localparam int unsigned NCH = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;

  logic              in_valid_q;
  logic [1:0]        in_op_q, in_chan_q;
  logic              out_valid_q;
  logic [FIELD_W-1:0] relay_q, status_q;
  logic [FIELD_W-1:0] relay_d, status_d;
  logic              advance;
  srs_cmd_t          cmd;

  logic [TIME_W-1:0] up_time   [TIME_CH];
  logic [TIME_W-1:0] down_time [TIME_CH];
  logic [1:0]        req_d [NCH];
  logic [1:0]        app_d [NCH];

  // the held item moves to the output when the output slot is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_chan_q <= s_axis_tdata[1:0];
    end
  end

  assign cmd = '{en: advance, op: in_op_q, chan: in_chan_q};

  srs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .up_time_o   (up_time),
    .down_time_o (down_time)
  );

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    srs_channel #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND),
      .CH_ID            (c)
    ) u_ch (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .up_time_i   (up_time[c]),
      .down_time_i (down_time[c]),
      .req_d_o     (req_d[c]),
      .app_d_o     (app_d[c])
    );
  end

  // result fields from the post-item channel state
  always_comb begin
    relay_d  = '0;
    status_d = '0;
    for (int c = 0; c < NCH; c++) begin
      relay_d[2*c]       = (app_d[c] == MOTION_UP);
      relay_d[2*c+1]     = (app_d[c] == MOTION_DOWN);
      status_d[2*c +: 2] = req_d[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      relay_q  <= relay_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, status_q, relay_q};

endmodule

// ===== test/shutter_relay_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// shutter_relay_sequencer_tb
// Self-checking bench for the three-channel shutter relay sequencer.
// Ticks and up/down/stop commands go in over s_axis. Each result on m_axis is
// compared field by field against a cycle-free model of the channels. Both
// sides throttle at random. Travel times are reprogrammed between phases,
// including out-of-range values.
// ----------------------------------------------------------------------------
module shutter_relay_sequencer_tb;
  import srs_pkg::*;

  localparam int unsigned NUM_CH       = 3;
  localparam int unsigned TPS          = 10;
  localparam int unsigned REPORT_LIMIT = 10;

  // Register indexes past the last travel time; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  // Relay drive and request status as seen on one result item
  typedef struct packed {
    logic [5:0] relay;
    logic [5:0] status;
  } shutter_view_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [TIME_W-1:0]    cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;   // [1:0] channel
  logic [1:0]           s_axis_tuser  = '0;   // [1:0] operation
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;         // [5:0] relay_drive, [11:6] packed_status

  shutter_relay_sequencer #(
    .CHANNELS        (NUM_CH),
    .TICKS_PER_SECOND(TPS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Channel model: request, applied motion and countdown per channel, plus
  // its own copy of the travel time registers.
  // --------------------------------------------------------------------------
  logic [1:0]        want_q   [NUM_CH];
  logic [1:0]        drive_q  [NUM_CH];
  logic [CNT_W-1:0]  left_q   [NUM_CH];
  logic [TIME_W-1:0] up_secs  [NUM_CH];
  logic [TIME_W-1:0] down_secs[NUM_CH];

  shutter_view_t awaited_views[$];

  // Bookkeeping for the summary
  int n_items, n_ticks, n_absent, n_writes, n_expiries, n_results, n_mismatches;

  // Source and sink throttling knobs, set per test
  bit source_throttle = 1'b0;
  bit sink_throttle   = 1'b0;
  int hold_off_left   = 0;   // long receiver hold-off, counted down by the sink
  int sink_stall_left = 0;

  // Mostly short gaps, now and then a long one
  function automatic int gap_length();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one item to the model and queue the result it must produce
  function automatic void step_shutters(input logic [1:0] op, input logic [1:0] ch);
    shutter_view_t     view;
    logic [TIME_W-1:0] secs;
    logic [31:0]       span;
    if (op == OP_TICK) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (want_q[c] != drive_q[c]) begin
          if (want_q[c] == MOTION_STOP || drive_q[c] != MOTION_STOP) begin
            // plain stop, or dead time ahead of a reversal
            drive_q[c] = MOTION_STOP;
          end else begin
            secs       = (want_q[c] == MOTION_UP) ? up_secs[c] : down_secs[c];
            span       = 32'(secs) * TPS;
            drive_q[c] = want_q[c];
            left_q[c]  = span[CNT_W-1:0];   // long times wrap to 16 bits
          end
        end else if (want_q[c] != MOTION_STOP) begin
          left_q[c] = left_q[c] - CNT_W'(1);  // zero load wraps to 65535
          if (left_q[c] == '0) begin
            want_q[c] = MOTION_STOP;
            n_expiries++;
          end
        end
      end
    end else if (ch < NUM_CH) begin
      case (op)
        OP_UP:   want_q[ch] = MOTION_UP;
        OP_DOWN: want_q[ch] = MOTION_DOWN;
        default: want_q[ch] = MOTION_STOP;
      endcase
    end else begin
      n_absent++;
    end

    view = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (drive_q[c] == MOTION_UP) view.relay[2*c] = 1'b1;
      else if (drive_q[c] == MOTION_DOWN) view.relay[2*c+1] = 1'b1;
      view.status[2*c +: 2] = want_q[c];
    end
    awaited_views.push_back(view);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one item and hold it until taken. tvalid stays high on return, so
  // the caller either sends again at once or goes through wait_for_idle.
  task automatic send_item(input logic [1:0] op, input logic [1:0] ch);
    int gap;
    if (source_throttle && $urandom_range(0, 2) == 0) begin
      gap           = gap_length();
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {6'b000000, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    step_shutters(op, ch);
    n_items++;
    if (op == OP_TICK) n_ticks++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every queued result has come back and the
  // input and output registers are empty.
  task automatic wait_for_idle();
    s_axis_tvalid = 1'b0;
    while (awaited_views.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Register write; only called with the block idle
  task automatic load_travel_time(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [TIME_W-1:0]    secs);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = secs;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx <= CFG_UP_TIME_CH2) up_secs[idx[1:0]] = secs;
    else if (idx <= CFG_DOWN_TIME_CH2) down_secs[2'(idx - CFG_DOWN_TIME_CH0)] = secs;
    n_writes++;
  endtask

  task automatic program_times(input logic [TIME_W-1:0] u0, u1, u2, d0, d1, d2);
    wait_for_idle();
    load_travel_time(CFG_UP_TIME_CH0,   u0);
    load_travel_time(CFG_UP_TIME_CH1,   u1);
    load_travel_time(CFG_UP_TIME_CH2,   u2);
    load_travel_time(CFG_DOWN_TIME_CH0, d0);
    load_travel_time(CFG_DOWN_TIME_CH1, d1);
    load_travel_time(CFG_DOWN_TIME_CH2, d2);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(OP_TICK, 2'($urandom_range(0, 3)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset travel times: start, reversal with dead time, stop, absent channel
  task automatic test_basic_sequencing();
    send_item(OP_TICK, 2'd0);        // idle tick, nothing moves
    send_item(OP_UP,   2'd0);
    send_item(OP_TICK, 2'd3);        // start up, channel field unused
    send_item(OP_TICK, 2'd0);        // countdown running
    send_item(OP_DOWN, 2'd0);        // reversal requested
    send_item(OP_TICK, 2'd1);        // dead time: both relays open
    send_item(OP_TICK, 2'd2);        // now down
    send_item(OP_STOP, 2'd0);
    send_item(OP_TICK, 2'd0);
    send_item(OP_UP,   2'd1);
    send_item(OP_DOWN, 2'd2);
    send_item(OP_UP,   2'd3);        // absent channel: ignored
    send_item(OP_DOWN, 2'd3);
    send_item(OP_STOP, 2'd3);
    send_item(OP_TICK, 2'd0);        // two channels start together
    send_item(OP_UP,   2'd2);        // reversal on channel 2
    send_item(OP_UP,   2'd1);        // repeated request, no change
    send_item(OP_TICK, 2'd0);
    send_item(OP_TICK, 2'd0);
    send_item(OP_STOP, 2'd1);
    send_item(OP_STOP, 2'd2);
    send_item(OP_TICK, 2'd3);
    wait_for_idle();
  endtask

  // Register extremes: wrap of long times, zero time, ignored indexes
  task automatic test_travel_time_limits();
    // 6554 s -> 65540 ticks, cut to 4; 8191 s cut to 16374; 0 runs 65536
    program_times(13'd6554, 13'd0, 13'd8191, 13'd1, 13'd6553, 13'd1);
    load_travel_time(CFG_SPARE_6, 13'd1);
    load_travel_time(CFG_SPARE_7, 13'h1FFF);
    send_item(OP_UP, 2'd0);
    send_ticks(7);                   // start, four decrements to expiry, stop
    send_item(OP_UP, 2'd1);
    send_item(OP_UP, 2'd2);
    send_ticks(3);
    send_item(OP_DOWN, 2'd0);
    send_ticks(13);                  // ten-tick run and the stop after it
    send_item(OP_STOP, 2'd1);
    send_item(OP_STOP, 2'd2);
    send_ticks(2);
    wait_for_idle();
  endtask

  // Mostly a command followed by a run of ticks, the rest loose items
  task automatic test_random_traffic(input int count, input bit throttled,
                                     input bit mid_pause);
    logic [1:0] cmd_codes[3] = '{OP_UP, OP_DOWN, OP_STOP};
    int sent;
    int run;
    source_throttle = throttled;
    sink_throttle   = throttled;
    sent            = 0;
    while (sent < count) begin
      if (mid_pause && sent >= count / 2 && sent < count / 2 + 20) begin
        wait_for_idle();             // sender rests until all results are in
        mid_pause = 1'b0;
      end
      if ($urandom_range(0, 9) < 7) begin
        send_item(cmd_codes[$urandom_range(0, 2)], 2'($urandom_range(0, 2)));
        run = $urandom_range(0, 14);
        send_ticks(run);
        sent += run + 1;
      end else begin
        send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        sent++;
      end
    end
    wait_for_idle();
  endtask

  // Receiver stalls for a long stretch while items keep coming
  task automatic test_output_hold_off();
    source_throttle = 1'b0;
    sink_throttle   = 1'b0;
    hold_off_left   = 150;
    send_item(OP_UP, 2'd0);
    send_item(OP_DOWN, 2'd1);
    send_ticks(20);
    send_item(OP_STOP, 2'd0);
    send_ticks(12);
    hold_off_left = 60;
    send_ticks(10);
    wait_for_idle();
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, plus the long hold-off when requested
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready = 1'b0;
    end else if (hold_off_left > 0) begin
      m_axis_tready = 1'b0;
      hold_off_left--;
    end else if (!sink_throttle) begin
      m_axis_tready = 1'b1;
    end else if (sink_stall_left > 0) begin
      m_axis_tready = 1'b0;
      sink_stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready   = 1'b0;
      sink_stall_left = gap_length() - 1;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  function automatic void flag_mismatch(input string field, input int unsigned got,
                                        input int unsigned wanted);
    n_mismatches++;
    if (n_mismatches <= REPORT_LIMIT)
      $display("%0t result %0d %s: expected 0x%0h, got 0x%0h",
               $time, n_results, field, wanted, got);
  endfunction

  // Compare each result with the oldest outstanding prediction
  always @(posedge clk_i) begin : check_results
    shutter_view_t head;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (awaited_views.size() == 0) begin
        flag_mismatch("arrived with nothing pending, tdata", 32'(m_axis_tdata), 0);
      end else begin
        head = awaited_views.pop_front();
        if (m_axis_tdata[5:0] != head.relay)
          flag_mismatch("relay_drive", 32'(m_axis_tdata[5:0]), 32'(head.relay));
        if (m_axis_tdata[11:6] != head.status)
          flag_mismatch("packed_status", 32'(m_axis_tdata[11:6]), 32'(head.status));
        if (m_axis_tdata[15:12] != '0)
          flag_mismatch("tdata padding", 32'(m_axis_tdata[15:12]), 0);
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", awaited_views.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      want_q[c]    = MOTION_STOP;
      drive_q[c]   = MOTION_STOP;
      left_q[c]    = '0;
      up_secs[c]   = TIME_RESET;
      down_secs[c] = TIME_RESET;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_sequencing();
    test_travel_time_limits();

    // Short times so countdowns expire often; no idling in this phase
    program_times(13'd1, 13'd1, 13'd1, 13'd1, 13'd1, 13'd1);
    test_random_traffic(450, 1'b0, 1'b0);

    // Mixed short times, one wrapping to a four-tick run
    program_times(13'd2, 13'd6554, 13'd1, 13'd3, 13'd1, 13'd4);
    test_random_traffic(450, 1'b1, 1'b1);

    // Anything the 13-bit field allows
    program_times(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                  13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                  13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
    test_random_traffic(350, 1'b1, 1'b0);

    // Longest legal time upward, shortest downward
    program_times(13'd6553, 13'd6553, 13'd6553, 13'd1, 13'd1, 13'd1);
    test_random_traffic(350, 1'b1, 1'b1);

    test_output_hold_off();

    program_times(13'd2, 13'd1, 13'd3, 13'd1, 13'd2, 13'd1);
    test_random_traffic(250, 1'b1, 1'b0);

    wait_for_idle();
    repeat (5) @(negedge clk_i);

    $display("Ran %0d items (%0d ticks, %0d commands to the absent channel), %0d register writes",
             n_items, n_ticks, n_absent, n_writes);
    $display("Saw %0d travel countdown expiries; checked %0d results, %0d mismatches",
             n_expiries, n_results, n_mismatches);
    if (n_mismatches == 0 && awaited_views.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
